// ----- design/sbic_pkg.sv -----
// Shared types and constants for the integer stack bytecode core.
// Opcode values, status codes, result layout and the stack update record.
// No dependencies.
package sbic_pkg;

  typedef logic [31:0] word_t;

  // Number of stack entries held in registers above the stack memory.
  localparam int CACHED = 3;
  // Locals reachable by the short load and store forms.
  localparam int LOCALS_HELD = 4;

  typedef logic [LOCALS_HELD-1:0][31:0] local_vec_t;

  localparam logic [7:0] OPC_ICONST_M1 = 8'd2;
  localparam logic [7:0] OPC_ICONST_5  = 8'd8;
  localparam logic [7:0] OPC_BIPUSH    = 8'd16;
  localparam logic [7:0] OPC_ILOAD_0   = 8'd26;
  localparam logic [7:0] OPC_ILOAD_3   = 8'd29;
  localparam logic [7:0] OPC_ALOAD_0   = 8'd42;
  localparam logic [7:0] OPC_ALOAD_3   = 8'd45;
  localparam logic [7:0] OPC_ISTORE_0  = 8'd59;
  localparam logic [7:0] OPC_ISTORE_3  = 8'd62;
  localparam logic [7:0] OPC_ASTORE_0  = 8'd75;
  localparam logic [7:0] OPC_ASTORE_3  = 8'd78;
  localparam logic [7:0] OPC_POP       = 8'd87;
  localparam logic [7:0] OPC_DUP       = 8'd89;
  localparam logic [7:0] OPC_IADD      = 8'd96;
  localparam logic [7:0] OPC_ISUB      = 8'd100;
  localparam logic [7:0] OPC_IMUL      = 8'd104;
  localparam logic [7:0] OPC_IINC      = 8'd132;
  localparam logic [7:0] OPC_IFEQ      = 8'd153;
  localparam logic [7:0] OPC_IFNE      = 8'd154;
  localparam logic [7:0] OPC_IF_ICMPNE = 8'd160;
  localparam logic [7:0] OPC_IF_ICMPGT = 8'd163;
  localparam logic [7:0] OPC_GOTO      = 8'd167;
  localparam logic [7:0] OPC_IRETURN   = 8'd172;
  localparam logic [7:0] OPC_RETURN    = 8'd177;

  // iconst_m1 .. iconst_5 push (opcode - 3)
  localparam word_t ICONST_BIAS = 32'd3;

  localparam logic [15:0] LEN_ONE   = 16'd1;
  localparam logic [15:0] LEN_TWO   = 16'd2;
  localparam logic [15:0] LEN_THREE = 16'd3;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNDER     = 3'd1,
    ST_OVER      = 3'd2,
    ST_UNHANDLED = 3'd3,
    ST_LOCAL     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    SK_HOLD,
    SK_PUSH,
    SK_POP1,
    SK_POP2,
    SK_FOLD   // pop two, push one
  } stack_op_t;

  typedef struct packed {
    stack_op_t   kind;
    word_t       value;
    logic        loc_we;
    logic [1:0]  loc_idx;
    word_t       loc_val;
  } stack_update_t;

  typedef struct packed {
    logic signed [15:0] pc_advance;
    logic               branch_taken;
    logic               finished;
    logic               returns_value;
    logic signed [31:0] return_value;
    logic [2:0]         status;
    logic [6:0]         stack_depth;
    logic signed [31:0] top_value;
  } result_t;

endpackage

// ----- design/sbic_in_if.sv -----
// Instruction request channel of the integer stack bytecode core.
// Carries opcode and two operand bytes. No dependencies.
interface sbic_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] opcode;
  logic [7:0] operand_high;
  logic [7:0] operand_low;

  modport source (output valid, output opcode, output operand_high, output operand_low,
                  input ready);
  modport sink   (input valid, input opcode, input operand_high, input operand_low,
                  output ready);
endinterface

// ----- design/sbic_out_if.sv -----
// Result channel of the integer stack bytecode core.
// One result per executed instruction. No dependencies.
interface sbic_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pc_advance;
  logic               branch_taken;
  logic               finished;
  logic               returns_value;
  logic signed [31:0] return_value;
  logic [2:0]         status;
  logic [6:0]         stack_depth;
  logic signed [31:0] top_value;

  modport source (output valid, output pc_advance, output branch_taken, output finished,
                  output returns_value, output return_value, output status,
                  output stack_depth, output top_value, input ready);
  modport sink   (input valid, input pc_advance, input branch_taken, input finished,
                  input returns_value, input return_value, input status,
                  input stack_depth, input top_value, output ready);
endinterface

// ----- design/stack_bytecode_integer_core_top.sv -----
// Top level of the integer stack bytecode core: stack memory, top-of-stack
// cache, locals, and a two-entry result buffer.
// Depends on sbic_pkg, sbic_in_if, sbic_out_if, sbic_exec.
//
//   channel   role   carries
//   instr     sink   opcode, operand_high, operand_low
//   result    source pc_advance .. top_value, one per request
//
// One request per cycle while instr.ready is high; its result is registered and
// shows the next cycle unless the output stalls. The top three stack entries live
// in registers; the two below them are read from the stack memory every cycle for
// the next request, so pops of one or two entries never wait. Reset clears the stack
// pointer and locals at once. instr.ready drops only when both buffer entries are full.
module stack_bytecode_integer_core_top #(
  parameter int STACK_DEPTH = 64,
  parameter int LOCAL_COUNT = 256
) (
  input  logic     clk,
  input  logic     rst,
  sbic_in_if.sink  instr,
  sbic_out_if.source result
);
  import sbic_pkg::*;

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int AW  = $clog2(STACK_DEPTH);

  logic [SPW-1:0] sp, sp_next, sp_look, wr_ptr, rd_ptr0, rd_ptr1;
  word_t          top0, top1, top2, deep0, deep1;
  local_vec_t     locals;
  word_t          stack_mem [STACK_DEPTH];
  result_t        res, out_data, skid_data;
  stack_update_t  upd;
  logic           out_valid, skid_valid, accept, take;

  sbic_exec #(
    .STACK_DEPTH (STACK_DEPTH),
    .LOCAL_COUNT (LOCAL_COUNT)
  ) u_exec (
    .opcode       (instr.opcode),
    .operand_high (instr.operand_high),
    .operand_low  (instr.operand_low),
    .sp           (sp),
    .top0         (top0),
    .top1         (top1),
    .top2         (top2),
    .locals       (locals),
    .res          (res),
    .upd          (upd),
    .sp_next      (sp_next)
  );

  assign instr.ready = !skid_valid;
  assign accept      = instr.valid && instr.ready;
  assign take        = !out_valid || result.ready;

  assign sp_look = accept ? sp_next : sp;
  assign wr_ptr  = sp_next - SPW'(1);
  assign rd_ptr0 = sp_look - SPW'(CACHED + 1);
  assign rd_ptr1 = sp_look - SPW'(CACHED + 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      sp     <= '0;
      locals <= '0;
    end else if (accept) begin
      sp <= sp_next;
      if (upd.loc_we) locals[upd.loc_idx] <= upd.loc_val;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      unique case (upd.kind)
        SK_PUSH: begin top0 <= upd.value; top1 <= top0;  top2 <= top1;  end
        SK_FOLD: begin top0 <= upd.value; top1 <= top2;  top2 <= deep0; end
        SK_POP1: begin top0 <= top1;      top1 <= top2;  top2 <= deep0; end
        SK_POP2: begin top0 <= top2;      top1 <= deep0; top2 <= deep1; end
        default: ;
      endcase
    end
  end

  // writes land at sp_next-1, never at the two prefetched entries below the cache
  always_ff @(posedge clk) begin
    if (accept && (upd.kind == SK_PUSH || upd.kind == SK_FOLD))
      stack_mem[wr_ptr[AW-1:0]] <= upd.value;
    if (sp_look >= SPW'(CACHED + 1)) deep0 <= stack_mem[rd_ptr0[AW-1:0]];
    if (sp_look >= SPW'(CACHED + 2)) deep1 <= stack_mem[rd_ptr1[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
        if (accept) out_data <= res;
      end
    end else if (accept) begin
      skid_data  <= res;
      skid_valid <= 1'b1;
    end
  end

  assign result.valid         = out_valid;
  assign result.pc_advance    = out_data.pc_advance;
  assign result.branch_taken  = out_data.branch_taken;
  assign result.finished      = out_data.finished;
  assign result.returns_value = out_data.returns_value;
  assign result.return_value  = out_data.return_value;
  assign result.status        = out_data.status;
  assign result.stack_depth   = out_data.stack_depth;
  assign result.top_value     = out_data.top_value;

endmodule

// ----- design/sbic_exec.sv -----
// Execute unit: decodes one bytecode against the cached stack top and locals,
// gives the result record and the stack/local update. Depends on sbic_pkg.
module sbic_exec #(
  parameter int STACK_DEPTH = 64,
  parameter int LOCAL_COUNT = 256,
  localparam int SPW = $clog2(STACK_DEPTH + 1)
) (
  input  logic [7:0]             opcode,
  input  logic [7:0]             operand_high,
  input  logic [7:0]             operand_low,
  input  logic [SPW-1:0]         sp,
  input  sbic_pkg::word_t        top0,
  input  sbic_pkg::word_t        top1,
  input  sbic_pkg::word_t        top2,
  input  sbic_pkg::local_vec_t   locals,
  output sbic_pkg::result_t      res,
  output sbic_pkg::stack_update_t upd,
  output logic [SPW-1:0]         sp_next
);
  import sbic_pkg::*;

  logic        empty, short, full, idx_bad, idx_held;
  logic [1:0]  load_idx, store_idx;
  logic [15:0] adv, target;
  logic        taken, fin, rv;
  word_t       rval, val, inc, new_top;
  status_t     st;
  stack_op_t   kind;
  logic        loc_we;
  logic [1:0]  loc_idx;
  word_t       loc_val;

  assign empty     = sp == '0;
  assign short     = sp < SPW'(2);
  assign full      = sp >= SPW'(STACK_DEPTH);
  assign idx_bad   = {1'b0, operand_high} >= 9'(LOCAL_COUNT);
  assign idx_held  = operand_high < 8'(LOCALS_HELD);
  // int and reference forms sit 16 codes apart, so one base serves both
  assign load_idx  = 2'(opcode - OPC_ILOAD_0);
  assign store_idx = 2'(opcode - OPC_ISTORE_0);
  assign target    = {operand_high, operand_low};
  assign inc       = {{24{operand_low[7]}}, operand_low};

  always_comb begin
    adv     = LEN_ONE;
    taken   = 1'b0;
    fin     = 1'b0;
    rv      = 1'b0;
    rval    = '0;
    st      = ST_OK;
    kind    = SK_HOLD;
    val     = '0;
    loc_we  = 1'b0;
    loc_idx = '0;
    loc_val = '0;
    unique case (opcode) inside
      [OPC_ICONST_M1:OPC_ICONST_5]: begin
        if (full) st = ST_OVER;
        else begin
          kind = SK_PUSH;
          val  = {24'd0, opcode} - ICONST_BIAS;
        end
      end
      OPC_BIPUSH: begin
        adv = LEN_TWO;
        if (full) st = ST_OVER;
        else begin
          kind = SK_PUSH;
          val  = {{24{operand_high[7]}}, operand_high};
        end
      end
      [OPC_ILOAD_0:OPC_ILOAD_3], [OPC_ALOAD_0:OPC_ALOAD_3]: begin
        if (full) st = ST_OVER;
        else begin
          kind = SK_PUSH;
          val  = locals[load_idx];
        end
      end
      [OPC_ISTORE_0:OPC_ISTORE_3], [OPC_ASTORE_0:OPC_ASTORE_3]: begin
        if (empty) st = ST_UNDER;
        else begin
          kind    = SK_POP1;
          loc_we  = 1'b1;
          loc_idx = store_idx;
          loc_val = top0;
        end
      end
      OPC_POP: begin
        if (empty) st = ST_UNDER;
        else kind = SK_POP1;
      end
      OPC_DUP: begin
        if (empty) st = ST_UNDER;
        else if (full) st = ST_OVER;
        else begin
          kind = SK_PUSH;
          val  = top0;
        end
      end
      OPC_IADD, OPC_ISUB, OPC_IMUL: begin
        if (short) st = ST_UNDER;
        else begin
          kind = SK_FOLD;
          if (opcode == OPC_IADD) val = top1 + top0;
          else if (opcode == OPC_ISUB) val = top1 - top0;
          else val = top1 * top0;
        end
      end
      OPC_IINC: begin
        adv = LEN_THREE;
        if (idx_bad) st = ST_LOCAL;
        else if (idx_held) begin
          // locals above the short-form range are never loaded; only range-checked
          loc_we  = 1'b1;
          loc_idx = operand_high[1:0];
          loc_val = locals[operand_high[1:0]] + inc;
        end
      end
      OPC_IFEQ, OPC_IFNE: begin
        adv = LEN_THREE;
        if (empty) st = ST_UNDER;
        else begin
          kind  = SK_POP1;
          taken = (opcode == OPC_IFEQ) ? (top0 == '0) : (top0 != '0);
        end
      end
      OPC_IF_ICMPNE, OPC_IF_ICMPGT: begin
        adv = LEN_THREE;
        if (short) st = ST_UNDER;
        else begin
          kind  = SK_POP2;
          taken = (opcode == OPC_IF_ICMPNE) ? (top1 != top0)
                                            : ($signed(top1) > $signed(top0));
        end
      end
      OPC_GOTO: taken = 1'b1;
      OPC_IRETURN: begin
        if (empty) st = ST_UNDER;
        else begin
          kind = SK_POP1;
          rval = top0;
          rv   = 1'b1;
          fin  = 1'b1;
          adv  = '0;
        end
      end
      OPC_RETURN: begin
        fin = 1'b1;
        adv = '0;
      end
      default: st = ST_UNHANDLED;
    endcase
  end

  always_comb begin
    unique case (kind)
      SK_PUSH: begin sp_next = sp + SPW'(1); new_top = val;  end
      SK_FOLD: begin sp_next = sp - SPW'(1); new_top = val;  end
      SK_POP1: begin sp_next = sp - SPW'(1); new_top = top1; end
      SK_POP2: begin sp_next = sp - SPW'(2); new_top = top2; end
      default: begin sp_next = sp;           new_top = top0; end
    endcase
  end

  assign upd.kind    = kind;
  assign upd.value   = val;
  assign upd.loc_we  = loc_we;
  assign upd.loc_idx = loc_idx;
  assign upd.loc_val = loc_val;

  assign res.pc_advance    = taken ? target : adv;
  assign res.branch_taken  = taken;
  assign res.finished      = fin;
  assign res.returns_value = rv;
  assign res.return_value  = rval;
  assign res.status        = st;
  assign res.stack_depth   = 7'(sp_next);
  assign res.top_value     = (sp_next == '0) ? '0 : new_top;

endmodule

// ----- tb/stack_bytecode_integer_core_top_test.sv -----
// Self-checking bench for stack_bytecode_integer_core_top: a scoreboard class
// predicts each result from its own stack and locals; directed and random requests drive it.
// Depends on sbic_pkg, sbic_in_if, sbic_out_if and the core's RTL.
module stack_bytecode_integer_core_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sbic_pkg::*;

  localparam int STACK_DEPTH  = 64;
  localparam int LOCAL_COUNT  = 256;
  localparam int RANDOM_ITEMS = 975;
  localparam int CALM_TAIL    = 150;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 4;

  typedef enum int {WALK_MIX, WALK_FILL, WALK_DRAIN} walk_t;

  class bytecode_scoreboard;
    word_t       stack_mem[STACK_DEPTH];
    word_t       locals[LOCAL_COUNT];
    int unsigned depth;
    result_t     expected_results[$];
    int          errors;
    int          requests;
    int          status_seen[5];
    int          taken_seen;
    int          returns_seen;

    function new();
      foreach (stack_mem[i]) stack_mem[i] = '0;
      foreach (locals[i]) locals[i] = '0;
      depth = 0;
      errors = 0;
      requests = 0;
      taken_seen = 0;
      returns_seen = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function status_t room(int unsigned pops, int unsigned pushes);
      if (depth < pops) return ST_UNDER;
      if (depth - pops + pushes > STACK_DEPTH) return ST_OVER;
      return ST_OK;
    endfunction

    function void push_word(word_t v);
      stack_mem[depth] = v;
      depth++;
    endfunction

    function word_t pop_word();
      depth--;
      return stack_mem[depth];
    endfunction

    function result_t execute_bytecode(logic [7:0] op, logic [7:0] hi, logic [7:0] lo);
      result_t     r;
      status_t     st;
      logic [15:0] adv;
      logic        taken;
      word_t       a;
      word_t       b;
      logic [7:0]  slot;

      r = '0;
      adv = LEN_ONE;
      taken = 1'b0;
      st = ST_OK;
      if (op >= OPC_ICONST_M1 && op <= OPC_ICONST_5) begin
        st = room(0, 1);
        if (st == ST_OK) push_word(word_t'(op) - ICONST_BIAS);
      end else if ((op >= OPC_ILOAD_0 && op <= OPC_ILOAD_3) ||
                   (op >= OPC_ALOAD_0 && op <= OPC_ALOAD_3)) begin
        slot = (op >= OPC_ALOAD_0) ? op - OPC_ALOAD_0 : op - OPC_ILOAD_0;
        st = room(0, 1);
        if (st == ST_OK) push_word(locals[slot[1:0]]);
      end else if ((op >= OPC_ISTORE_0 && op <= OPC_ISTORE_3) ||
                   (op >= OPC_ASTORE_0 && op <= OPC_ASTORE_3)) begin
        slot = (op >= OPC_ASTORE_0) ? op - OPC_ASTORE_0 : op - OPC_ISTORE_0;
        st = room(1, 0);
        if (st == ST_OK) locals[slot[1:0]] = pop_word();
      end else begin
        case (op)
          OPC_BIPUSH: begin
            adv = LEN_TWO;
            st = room(0, 1);
            if (st == ST_OK) push_word({{24{hi[7]}}, hi});
          end
          OPC_POP: begin
            st = room(1, 0);
            if (st == ST_OK) a = pop_word();
          end
          OPC_DUP: begin
            st = room(1, 2);
            if (st == ST_OK) push_word(stack_mem[depth-1]);
          end
          OPC_IADD, OPC_ISUB, OPC_IMUL: begin
            st = room(2, 1);
            if (st == ST_OK) begin
              b = pop_word();
              a = pop_word();
              if (op == OPC_IADD) push_word(a + b);
              else if (op == OPC_ISUB) push_word(a - b);
              else push_word(a * b);
            end
          end
          OPC_IINC: begin
            adv = LEN_THREE;
            if (int'(hi) >= LOCAL_COUNT) st = ST_LOCAL;
            else locals[hi] = locals[hi] + {{24{lo[7]}}, lo};
          end
          OPC_IFEQ, OPC_IFNE: begin
            adv = LEN_THREE;
            st = room(1, 0);
            if (st == ST_OK) begin
              a = pop_word();
              taken = (op == OPC_IFEQ) ? (a == '0) : (a != '0);
            end
          end
          OPC_IF_ICMPNE, OPC_IF_ICMPGT: begin
            adv = LEN_THREE;
            st = room(2, 0);
            if (st == ST_OK) begin
              b = pop_word();
              a = pop_word();
              taken = (op == OPC_IF_ICMPNE) ? (a != b) : ($signed(a) > $signed(b));
            end
          end
          OPC_GOTO: taken = 1'b1;
          OPC_IRETURN: begin
            st = room(1, 0);
            if (st == ST_OK) begin
              r.return_value = pop_word();
              r.returns_value = 1'b1;
              r.finished = 1'b1;
              adv = '0;
            end
          end
          OPC_RETURN: begin
            r.finished = 1'b1;
            adv = '0;
          end
          default: st = ST_UNHANDLED;
        endcase
      end
      r.branch_taken = taken;
      r.pc_advance = taken ? {hi, lo} : adv;
      r.status = st;
      r.stack_depth = depth[6:0];
      r.top_value = (depth > 0) ? stack_mem[depth-1] : '0;
      return r;
    endfunction

    function void note_request(logic [7:0] op, logic [7:0] hi, logic [7:0] lo);
      result_t r;
      r = execute_bytecode(op, hi, lo);
      requests++;
      status_seen[r.status]++;
      if (r.branch_taken) taken_seen++;
      if (r.finished) returns_seen++;
      expected_results.push_back(r);
    endfunction

    function bit field_ok(string name, logic [31:0] exp, logic [31:0] got);
      if (exp === got) return 1'b1;
      $error("%s: expected %h, actual %h", name, exp, got);
      return 1'b0;
    endfunction

    function void check_result(result_t got);
      result_t exp;
      bit      ok;
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      exp = expected_results.pop_front();
      ok = 1'b1;
      ok &= field_ok("pc_advance", 32'(exp.pc_advance), 32'(got.pc_advance));
      ok &= field_ok("branch_taken", 32'(exp.branch_taken), 32'(got.branch_taken));
      ok &= field_ok("finished", 32'(exp.finished), 32'(got.finished));
      ok &= field_ok("returns_value", 32'(exp.returns_value), 32'(got.returns_value));
      ok &= field_ok("return_value", exp.return_value, got.return_value);
      ok &= field_ok("status", 32'(exp.status), 32'(got.status));
      ok &= field_ok("stack_depth", 32'(exp.stack_depth), 32'(got.stack_depth));
      ok &= field_ok("top_value", exp.top_value, got.top_value);
      if (!ok) errors++;
    endfunction
  endclass

  logic clk;
  logic rst;
  logic bursts_on;
  int   quiet_cycles;
  int   stall_left;

  bytecode_scoreboard sb;

  sbic_in_if  instr_ch();
  sbic_out_if result_ch();

  stack_bytecode_integer_core_top #(
    .STACK_DEPTH(STACK_DEPTH),
    .LOCAL_COUNT(LOCAL_COUNT)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .instr(instr_ch),
    .result(result_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (instr_ch.valid && instr_ch.ready) begin
        sb.note_request(instr_ch.opcode, instr_ch.operand_high, instr_ch.operand_low);
      end
      if (result_ch.valid && result_ch.ready) begin
        result_t got;
        got.pc_advance = result_ch.pc_advance;
        got.branch_taken = result_ch.branch_taken;
        got.finished = result_ch.finished;
        got.returns_value = result_ch.returns_value;
        got.return_value = result_ch.return_value;
        got.status = result_ch.status;
        got.stack_depth = result_ch.stack_depth;
        got.top_value = result_ch.top_value;
        sb.check_result(got);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (instr_ch.valid && instr_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side back-pressure
  initial begin
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 4);
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_request(input logic [7:0] op, input logic [7:0] hi,
                              input logic [7:0] lo);
    int gap;
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      instr_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    instr_ch.valid <= 1'b1;
    instr_ch.opcode <= op;
    instr_ch.operand_high <= hi;
    instr_ch.operand_low <= lo;
    @(posedge clk);
    while (!instr_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    instr_ch.valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic send_random(input walk_t walk);
    int         r;
    int         push_cut;
    logic [7:0] op;
    logic [7:0] hi;
    logic [7:0] lo;
    hi = 8'($urandom);
    lo = 8'($urandom);
    r = $urandom_range(0, 99);
    push_cut = (walk == WALK_FILL) ? 80 : (walk == WALK_DRAIN) ? 25 : 48;
    if (r < 6) begin
      op = 8'($urandom);
    end else if (r < push_cut) begin
      case ($urandom_range(0, 4))
        0: op = 8'($urandom_range(OPC_ICONST_M1, OPC_ICONST_5));
        1: op = OPC_BIPUSH;
        2: op = 8'($urandom_range(OPC_ILOAD_0, OPC_ILOAD_3));
        3: op = 8'($urandom_range(OPC_ALOAD_0, OPC_ALOAD_3));
        default: op = OPC_DUP;
      endcase
    end else if (r < 92) begin
      case ($urandom_range(0, 7))
        0: op = 8'($urandom_range(OPC_ISTORE_0, OPC_ISTORE_3));
        1: op = 8'($urandom_range(OPC_ASTORE_0, OPC_ASTORE_3));
        2: op = OPC_POP;
        3, 4: begin
          case ($urandom_range(0, 2))
            0: op = OPC_IADD;
            1: op = OPC_ISUB;
            default: op = OPC_IMUL;
          endcase
        end
        5: op = $urandom_range(0, 1) ? OPC_IFEQ : OPC_IFNE;
        6: op = $urandom_range(0, 1) ? OPC_IF_ICMPNE : OPC_IF_ICMPGT;
        default: op = OPC_IRETURN;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0: begin
          op = OPC_IINC;
          if ($urandom_range(0, 1)) hi = 8'($urandom_range(0, 3));
        end
        1: op = OPC_GOTO;
        default: op = OPC_RETURN;
      endcase
    end
    send_request(op, hi, lo);
  endtask

  initial begin
    int    sent;
    int    seg;
    int    seg_len;
    walk_t walk;

    sb = new();
    rst <= 1'b1;
    bursts_on <= 1'b1;
    instr_ch.valid <= 1'b0;
    instr_ch.opcode <= '0;
    instr_ch.operand_high <= '0;
    instr_ch.operand_low <= '0;
    result_ch.ready <= 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty-stack faults, extremes, every opcode family
    send_request(OPC_IRETURN, 8'h00, 8'h00);
    send_request(OPC_POP, 8'hff, 8'hff);
    send_request(OPC_IADD, 8'h00, 8'h00);
    send_request(OPC_ICONST_M1, 8'h00, 8'h00);
    send_request(OPC_ICONST_5, 8'h00, 8'h00);
    send_request(OPC_BIPUSH, 8'h80, 8'h00);
    send_request(OPC_BIPUSH, 8'h7f, 8'hff);
    send_request(OPC_IMUL, 8'h00, 8'h00);
    send_request(OPC_DUP, 8'h00, 8'h00);
    send_request(OPC_ISUB, 8'h00, 8'h00);
    send_request(OPC_ISTORE_0, 8'h00, 8'h00);
    send_request(OPC_IINC, 8'h00, 8'h80);
    send_request(OPC_IINC, 8'hff, 8'h7f);
    send_request(OPC_ILOAD_0, 8'h00, 8'h00);
    send_request(OPC_ASTORE_3, 8'h00, 8'h00);
    send_request(OPC_ALOAD_3, 8'h00, 8'h00);
    send_request(OPC_ICONST_M1 + 8'd3, 8'h00, 8'h00);
    send_request(OPC_IFEQ, 8'hff, 8'hff);
    send_request(OPC_IFNE, 8'h80, 8'h00);
    send_request(OPC_BIPUSH, 8'hfe, 8'h00);
    send_request(OPC_IF_ICMPGT, 8'h00, 8'h10);
    send_request(OPC_IF_ICMPNE, 8'h7f, 8'hff);
    send_request(OPC_GOTO, 8'h12, 8'h34);
    send_request(OPC_RETURN, 8'h00, 8'h00);
    send_request(8'hb6, 8'h00, 8'h00);

    sent = 0;
    seg = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0: walk = WALK_MIX;
        1: walk = WALK_FILL;
        default: walk = WALK_DRAIN;
      endcase
      seg_len = $urandom_range(30, 120);
      if ($urandom_range(0, 3) == 0) bursts_on <= 1'b0;
      else bursts_on <= (sent < RANDOM_ITEMS - CALM_TAIL);
      repeat (seg_len) begin
        if (sent < RANDOM_ITEMS) begin
          send_random(walk);
          sent++;
        end
      end
      if (seg == 0 || $urandom_range(0, 3) == 0) hold_until_drained();
      seg++;
    end

    bursts_on <= 1'b0;
    instr_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests: %0d ok, %0d underflow, %0d overflow, %0d unhandled, %0d bad local",
             sb.requests, sb.status_seen[ST_OK], sb.status_seen[ST_UNDER],
             sb.status_seen[ST_OVER], sb.status_seen[ST_UNHANDLED], sb.status_seen[ST_LOCAL]);
    $display("%0d branches taken, %0d returns, %0d mismatching results",
             sb.taken_seen, sb.returns_seen, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
